// ===== src/jdq_pkg.sv =====
// shared types, codes and constants of the joystick direction qualifier
package jdq_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int SUM_W      = 18;
	localparam int PCT_W      = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// divide by 100 as multiply by reciprocal, exact for 20-bit magnitudes
	localparam int PCT_MAG_W   = 20;
	localparam int PCT_RECIP_W = 21;
	localparam int PCT_SHIFT   = 27;
	localparam logic [PCT_RECIP_W-1:0] PCT_RECIP = 21'd1342178;

	localparam logic OP_CAL  = 1'b0;
	localparam logic OP_POLL = 1'b1;

	localparam logic [PCT_W-1:0]    MOVE_PERCENT_RST = 7'd55;
	localparam logic [SAMPLE_W-1:0] MIN_THRESH_RST   = 12'd250;
	localparam logic [SAMPLE_W-1:0] MAX_THRESH_RST   = 12'd900;
	localparam logic [SAMPLE_W-1:0] RELEASE_RST      = 12'd180;
	localparam logic [SAMPLE_W-1:0] FULL_SCALE_RST   = 12'd4095;
	localparam logic [SAMPLE_W-1:0] CENTRE_RST       = 12'd2048;
	localparam logic [SAMPLE_W-1:0] THRESH_RST       = 12'd900;

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef enum logic [2:0] {
		MOVE_NONE  = 3'd0,
		MOVE_LEFT  = 3'd1,
		MOVE_RIGHT = 3'd2,
		MOVE_DOWN  = 3'd3,
		MOVE_UP    = 3'd4
	} dir_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MOVE_PERCENT     = 3'd0,
		CFG_MIN_THRESHOLD    = 3'd1,
		CFG_MAX_THRESHOLD    = 3'd2,
		CFG_RELEASE_DISTANCE = 3'd3,
		CFG_ADC_FULL_SCALE   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [PCT_W-1:0] move_percent;
		sample_t          min_threshold;
		sample_t          max_threshold;
		sample_t          release_distance;
		sample_t          adc_full_scale;
	} cfg_t;

	typedef struct packed {
		sample_t centre_x;
		sample_t centre_y;
		sample_t thr_left;
		sample_t thr_right;
		sample_t thr_up;
		sample_t thr_down;
	} cal_state_t;

	typedef struct packed {
		logic cal_last;
		logic busy;
		logic finish;
		logic cal_done;
	} cal_status_t;

	typedef struct packed {
		dir_t direction;
		logic awaiting_release;
		logic calibrated;
	} result_t;

endpackage

// ===== src/joystick_direction_qualifier_top.sv =====
// Joystick direction qualifier: takes one X/Y sample pair per beat, either a
// calibration sample at rest or a navigation poll, and returns one result beat
// per input beat through the result register or its skid entry. Polls and
// ordinary calibration samples are taken every cycle while in_stall is low.
// The last calibration sample of a set (CAL_SAMPLES of them) holds in_stall
// high while the centres and the four move thresholds are worked out through
// the divide, centre, scale, reciprocal and clamp stages of the calibration
// unit; its result beat comes out when the new thresholds are in place.
// in_stall also rises when the result register and its skid entry are full.
module joystick_direction_qualifier_top #(
	parameter int CAL_SAMPLES = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               operation,
	input  logic [jdq_pkg::SAMPLE_W-1:0]       x_sample,
	input  logic [jdq_pkg::SAMPLE_W-1:0]       y_sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [2:0]                         direction,
	output logic                               awaiting_release,
	output logic                               calibrated,
	input  logic                               cfg_we,
	input  logic [jdq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [jdq_pkg::CFG_DATA_W-1:0]     cfg_data
);

	jdq_pkg::cfg_t        cfg_q;
	jdq_pkg::cal_state_t  cal;
	jdq_pkg::cal_status_t cal_st;
	jdq_pkg::dir_t        dir;
	jdq_pkg::result_t     res, out_res;
	logic                 in_beat, cal_beat, poll_beat;
	logic                 latch_nxt, latch_q, push, skid_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.move_percent     <= jdq_pkg::MOVE_PERCENT_RST;
			cfg_q.min_threshold    <= jdq_pkg::MIN_THRESH_RST;
			cfg_q.max_threshold    <= jdq_pkg::MAX_THRESH_RST;
			cfg_q.release_distance <= jdq_pkg::RELEASE_RST;
			cfg_q.adc_full_scale   <= jdq_pkg::FULL_SCALE_RST;
		end else if (cfg_we) begin
			unique case (jdq_pkg::cfg_idx_t'(cfg_index))
				jdq_pkg::CFG_MOVE_PERCENT:
					cfg_q.move_percent <= cfg_data[jdq_pkg::PCT_W-1:0];
				jdq_pkg::CFG_MIN_THRESHOLD:    cfg_q.min_threshold    <= cfg_data;
				jdq_pkg::CFG_MAX_THRESHOLD:    cfg_q.max_threshold    <= cfg_data;
				jdq_pkg::CFG_RELEASE_DISTANCE: cfg_q.release_distance <= cfg_data;
				jdq_pkg::CFG_ADC_FULL_SCALE:   cfg_q.adc_full_scale   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall  = cal_st.busy || skid_full;
	assign in_beat   = in_valid && !in_stall;
	assign cal_beat  = in_beat && (operation == jdq_pkg::OP_CAL);
	assign poll_beat = in_beat && (operation == jdq_pkg::OP_POLL);

	jdq_cal #(
		.CAL_SAMPLES(CAL_SAMPLES)
	) u_cal (
		.clk      (clk),
		.arst_n   (arst_n),
		.cal_beat (cal_beat),
		.x_sample (x_sample),
		.y_sample (y_sample),
		.cfg      (cfg_q),
		.cal      (cal),
		.status   (cal_st)
	);

	jdq_dir u_dir (
		.clk              (clk),
		.arst_n           (arst_n),
		.poll_beat        (poll_beat),
		.x_sample         (x_sample),
		.y_sample         (y_sample),
		.cal              (cal),
		.release_distance (cfg_q.release_distance),
		.direction        (dir),
		.latch_nxt        (latch_nxt),
		.latch_q          (latch_q)
	);

	// last calibration beat reports once the thresholds are done
	assign push = (in_beat && !cal_st.cal_last) || cal_st.finish;

	always_comb begin
		res.direction        = jdq_pkg::MOVE_NONE;
		res.awaiting_release = latch_q;
		res.calibrated       = cal_st.cal_done;
		if (poll_beat) begin
			res.direction        = dir;
			res.awaiting_release = latch_nxt;
		end
	end

	jdq_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_res  (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_res   (out_res),
		.skid_full (skid_full)
	);

	assign direction        = out_res.direction;
	assign awaiting_release = out_res.awaiting_release;
	assign calibrated       = out_res.calibrated;

endmodule

// ===== src/jdq_cal.sv =====
// calibration accumulator and multi-cycle centre and threshold computation
module jdq_cal #(
	parameter int CAL_SAMPLES = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cal_beat,
	input  jdq_pkg::sample_t    x_sample,
	input  jdq_pkg::sample_t    y_sample,
	input  jdq_pkg::cfg_t       cfg,
	output jdq_pkg::cal_state_t cal,
	output jdq_pkg::cal_status_t status
);

	localparam int CAL_LOG   = $clog2(CAL_SAMPLES);
	localparam int CNT_W     = (CAL_LOG > 0) ? CAL_LOG : 1;
	localparam int CAL_SHIFT = jdq_pkg::SUM_W + CAL_LOG;
	localparam int RECIP_W   = jdq_pkg::SUM_W + 1;
	localparam int QPROD_W   = jdq_pkg::SUM_W + RECIP_W;
	localparam longint unsigned CAL_RECIP_L =
		((64'd1 << CAL_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES;
	localparam logic [RECIP_W-1:0] CAL_RECIP = RECIP_W'(CAL_RECIP_L);
	localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(CAL_SAMPLES - 1);

	localparam int RNG_W   = jdq_pkg::SAMPLE_W + 1;
	localparam int PROD_W  = 21;
	localparam int PPROD_W = jdq_pkg::PCT_MAG_W + jdq_pkg::PCT_RECIP_W;
	localparam int QUO_W   = jdq_pkg::SAMPLE_W + 1;

	localparam int SIDE_LEFT  = 0;
	localparam int SIDE_RIGHT = 1;
	localparam int SIDE_UP    = 2;
	localparam int SIDE_DOWN  = 3;

	typedef enum logic [5:0] {
		FIN_IDLE   = 6'b000001,
		FIN_DIVIDE = 6'b000010,
		FIN_CENTRE = 6'b000100,
		FIN_SCALE  = 6'b001000,
		FIN_RECIP  = 6'b010000,
		FIN_CLAMP  = 6'b100000
	} fin_state_t;

	fin_state_t                   state_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [jdq_pkg::SUM_W-1:0]    sum_x_q, sum_y_q;
	logic [jdq_pkg::SUM_W-1:0]    sum_x_add, sum_y_add;
	logic                         cal_done_q;
	jdq_pkg::cal_state_t          cal_q;
	logic [QPROD_W-1:0]           quot_x_s1, quot_y_s1;
	logic signed [RNG_W-1:0]      range_d [4];
	logic signed [PROD_W-1:0]     rng_prod_d [4];
	logic signed [PROD_W-1:0]     rng_prod_s2 [4];
	logic [3:0]                   pos_s3;
	logic [PPROD_W-1:0]           recip_s3 [4];
	logic [jdq_pkg::SAMPLE_W-1:0] thr_d [4];
	logic [QUO_W-1:0]             quo_d [4];
	logic                         cal_last;

	assign sum_x_add = sum_x_q +
		{{(jdq_pkg::SUM_W - jdq_pkg::SAMPLE_W){1'b0}}, x_sample};
	assign sum_y_add = sum_y_q +
		{{(jdq_pkg::SUM_W - jdq_pkg::SAMPLE_W){1'b0}}, y_sample};
	assign cal_last = cal_beat && (cnt_q == CNT_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			sum_x_q    <= '0;
			sum_y_q    <= '0;
			cal_done_q <= 1'b0;
		end else begin
			if (cal_beat) begin
				sum_x_q <= sum_x_add;
				sum_y_q <= sum_y_add;
				cnt_q   <= cal_last ? '0 : cnt_q + 1'b1;
			end else if (state_q == FIN_DIVIDE) begin
				sum_x_q <= '0;
				sum_y_q <= '0;
			end
			if (cal_last) begin
				cal_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FIN_IDLE;
		end else begin
			unique case (state_q)
				FIN_IDLE:   if (cal_last) state_q <= FIN_DIVIDE;
				FIN_DIVIDE: state_q <= FIN_CENTRE;
				FIN_CENTRE: state_q <= FIN_SCALE;
				FIN_SCALE:  state_q <= FIN_RECIP;
				FIN_RECIP:  state_q <= FIN_CLAMP;
				FIN_CLAMP:  state_q <= FIN_IDLE;
				default:    state_q <= FIN_IDLE;
			endcase
		end
	end

	// available range to each side, signed since full scale may sit below centre
	always_comb begin
		range_d[SIDE_LEFT]  = $signed({1'b0, cal_q.centre_x});
		range_d[SIDE_RIGHT] = $signed({1'b0, cfg.adc_full_scale}) -
			$signed({1'b0, cal_q.centre_x});
		range_d[SIDE_UP]    = $signed({1'b0, cal_q.centre_y});
		range_d[SIDE_DOWN]  = $signed({1'b0, cfg.adc_full_scale}) -
			$signed({1'b0, cal_q.centre_y});
		for (int i = 0; i < 4; i++) begin
			rng_prod_d[i] = $signed({{(PROD_W - RNG_W){range_d[i][RNG_W-1]}}, range_d[i]}) *
				$signed({{(PROD_W - jdq_pkg::PCT_W){1'b0}}, cfg.move_percent});
		end
	end

	// nonpositive scaled range always clamps to the minimum
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			quo_d[i] = recip_s3[i][jdq_pkg::PCT_SHIFT +: QUO_W];
			if (!pos_s3[i]) begin
				thr_d[i] = cfg.min_threshold;
			end else if (quo_d[i] < {1'b0, cfg.min_threshold}) begin
				thr_d[i] = cfg.min_threshold;
			end else if (quo_d[i] > {1'b0, cfg.max_threshold}) begin
				thr_d[i] = cfg.max_threshold;
			end else begin
				thr_d[i] = quo_d[i][jdq_pkg::SAMPLE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FIN_DIVIDE) begin
			quot_x_s1 <= QPROD_W'(sum_x_q) * QPROD_W'(CAL_RECIP);
			quot_y_s1 <= QPROD_W'(sum_y_q) * QPROD_W'(CAL_RECIP);
		end
		if (state_q == FIN_SCALE) begin
			for (int i = 0; i < 4; i++) begin
				rng_prod_s2[i] <= rng_prod_d[i];
			end
		end
		if (state_q == FIN_RECIP) begin
			for (int i = 0; i < 4; i++) begin
				pos_s3[i]   <= !rng_prod_s2[i][PROD_W-1] && (rng_prod_s2[i] != '0);
				recip_s3[i] <= PPROD_W'(rng_prod_s2[i][jdq_pkg::PCT_MAG_W-1:0]) *
					PPROD_W'(jdq_pkg::PCT_RECIP);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q.centre_x  <= jdq_pkg::CENTRE_RST;
			cal_q.centre_y  <= jdq_pkg::CENTRE_RST;
			cal_q.thr_left  <= jdq_pkg::THRESH_RST;
			cal_q.thr_right <= jdq_pkg::THRESH_RST;
			cal_q.thr_up    <= jdq_pkg::THRESH_RST;
			cal_q.thr_down  <= jdq_pkg::THRESH_RST;
		end else begin
			if (state_q == FIN_CENTRE) begin
				cal_q.centre_x <= quot_x_s1[CAL_SHIFT +: jdq_pkg::SAMPLE_W];
				cal_q.centre_y <= quot_y_s1[CAL_SHIFT +: jdq_pkg::SAMPLE_W];
			end
			if (state_q == FIN_CLAMP) begin
				cal_q.thr_left  <= thr_d[SIDE_LEFT];
				cal_q.thr_right <= thr_d[SIDE_RIGHT];
				cal_q.thr_up    <= thr_d[SIDE_UP];
				cal_q.thr_down  <= thr_d[SIDE_DOWN];
			end
		end
	end

	assign cal             = cal_q;
	assign status.cal_last = cal_last;
	assign status.busy     = (state_q != FIN_IDLE);
	assign status.finish   = (state_q == FIN_CLAMP);
	assign status.cal_done = cal_done_q;

endmodule

// ===== src/jdq_dir.sv =====
// direction decision and release latch for poll beats
module jdq_dir (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                poll_beat,
	input  jdq_pkg::sample_t    x_sample,
	input  jdq_pkg::sample_t    y_sample,
	input  jdq_pkg::cal_state_t cal,
	input  jdq_pkg::sample_t    release_distance,
	output jdq_pkg::dir_t       direction,
	output logic                latch_nxt,
	output logic                latch_q
);

	localparam int D_W = jdq_pkg::SAMPLE_W + 2;

	logic signed [D_W-1:0] dx, dy, mag_x, mag_y, rel;
	logic signed [D_W-1:0] th_left, th_right, th_up, th_down;
	logic                  centred;

	always_comb begin
		dx       = $signed({2'b00, x_sample}) - $signed({2'b00, cal.centre_x});
		dy       = $signed({2'b00, y_sample}) - $signed({2'b00, cal.centre_y});
		mag_x    = dx[D_W-1] ? -dx : dx;
		mag_y    = dy[D_W-1] ? -dy : dy;
		rel      = $signed({2'b00, release_distance});
		th_left  = $signed({2'b00, cal.thr_left});
		th_right = $signed({2'b00, cal.thr_right});
		th_up    = $signed({2'b00, cal.thr_up});
		th_down  = $signed({2'b00, cal.thr_down});
		centred  = (mag_x < rel) && (mag_y < rel);

		direction = jdq_pkg::MOVE_NONE;
		if (!latch_q) begin
			if (dx < -th_left) begin
				direction = jdq_pkg::MOVE_LEFT;
			end else if (dx > th_right) begin
				direction = jdq_pkg::MOVE_RIGHT;
			end else if (dy > th_down) begin
				direction = jdq_pkg::MOVE_DOWN;
			end else if (dy < -th_up) begin
				direction = jdq_pkg::MOVE_UP;
			end
		end
		latch_nxt = latch_q ? !centred : (direction != jdq_pkg::MOVE_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= 1'b0;
		end else if (poll_beat) begin
			latch_q <= latch_nxt;
		end
	end

endmodule

// ===== src/jdq_obuf.sv =====
// result register with a skid entry so one more input beat is taken under output stall
module jdq_obuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jdq_pkg::result_t push_res,
	input  logic             out_stall,
	output logic             out_valid,
	output jdq_pkg::result_t out_res,
	output logic             skid_full
);

	logic             out_valid_q, skid_valid_q;
	jdq_pkg::result_t out_q, skid_q;
	logic             out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= skid_valid_q && push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q  <= skid_q;
				skid_q <= push_res;
			end else begin
				out_q <= push_res;
			end
		end else if (push) begin
			skid_q <= push_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign skid_full = skid_valid_q;

endmodule

// ===== src/jdq_checker.sv =====
// port-level checks on the joystick direction qualifier, bound to the top level
module jdq_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [2:0]                     direction,
	input logic                           awaiting_release,
	input logic                           calibrated
);

	// a reported move always leaves the latch set
	a_dir_sets_latch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (direction != jdq_pkg::MOVE_NONE) |-> awaiting_release)
		else $error("direction reported without release latch");

	// a beat taken while the output is held must fill the skid or start calibration
	a_held_accept_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && out_valid && out_stall |=> in_stall)
		else $error("input not stalled after beat accepted under output stall");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid &&
			$stable(direction) && $stable(awaiting_release) && $stable(calibrated))
		else $error("stalled result beat changed");

endmodule

bind joystick_direction_qualifier_top jdq_checker u_jdq_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.direction        (direction),
	.awaiting_release (awaiting_release),
	.calibrated       (calibrated)
);

// ===== test/tb_top.sv =====
// self-checking bench for the joystick direction qualifier: directed table, then random beats
`timescale 1ns / 1ps

module tb_top;

	localparam int CAL_SAMPLES   = 24;
	localparam int SAMPLE_MAX    = (1 << jdq_pkg::SAMPLE_W) - 1;
	localparam int N_PHASES      = 10;
	localparam int PHASE_BEATS   = 165;
	localparam int SETTLE_CYCLES = 8;
	localparam int N_DIRECTED    = 25;

	localparam int SIDE_LEFT  = 0;
	localparam int SIDE_RIGHT = 1;
	localparam int SIDE_UP    = 2;
	localparam int SIDE_DOWN  = 3;

	typedef struct packed {
		logic             op;
		jdq_pkg::sample_t x;
		jdq_pkg::sample_t y;
		logic             typed;
		jdq_pkg::result_t want;
	} stim_row_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	logic                           in_stall;
	logic                           operation = jdq_pkg::OP_CAL;
	jdq_pkg::sample_t               x_sample  = '0;
	jdq_pkg::sample_t               y_sample  = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [2:0]                     direction;
	logic                           awaiting_release;
	logic                           calibrated;
	logic                           cfg_we    = 1'b0;
	logic [jdq_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [jdq_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	// predictor copy of the block state and settings
	jdq_pkg::cfg_t             cur_cfg;
	logic                      latch_q;
	jdq_pkg::sample_t          centre_x;
	jdq_pkg::sample_t          centre_y;
	jdq_pkg::sample_t          thr [4];
	logic [jdq_pkg::SUM_W-1:0] sum_x;
	logic [jdq_pkg::SUM_W-1:0] sum_y;
	int                        cal_count;
	logic                      cal_done;

	jdq_pkg::result_t expected_results [$];
	jdq_pkg::result_t oldest;
	int      error_count   = 0;
	int      beats_sent    = 0;
	int      results_seen  = 0;
	int      cal_sets      = 0;
	int      dir_events [5];
	int      send_idle_pct = 14;
	int      recv_idle_pct = 57;

	stim_row_t directed_rows [N_DIRECTED] = '{
		'{jdq_pkg::OP_POLL, 12'd2048, 12'd2048, 1'b1, '{jdq_pkg::MOVE_NONE,  1'b0, 1'b0}},
		'{jdq_pkg::OP_POLL, 12'd0,    12'd2048, 1'b1, '{jdq_pkg::MOVE_LEFT,  1'b1, 1'b0}},
		'{jdq_pkg::OP_POLL, 12'd4095, 12'd4095, 1'b1, '{jdq_pkg::MOVE_NONE,  1'b1, 1'b0}},
		'{jdq_pkg::OP_POLL, 12'd2048, 12'd2048, 1'b1, '{jdq_pkg::MOVE_NONE,  1'b0, 1'b0}},
		'{jdq_pkg::OP_POLL, 12'd4095, 12'd2048, 1'b1, '{jdq_pkg::MOVE_RIGHT, 1'b1, 1'b0}},
		// just inside the release distance on both axes
		'{jdq_pkg::OP_POLL, 12'd2227, 12'd1869, 1'b1, '{jdq_pkg::MOVE_NONE,  1'b0, 1'b0}},
		'{jdq_pkg::OP_POLL, 12'd2048, 12'd4095, 1'b1, '{jdq_pkg::MOVE_DOWN,  1'b1, 1'b0}},
		// exactly at the release distance, latch holds
		'{jdq_pkg::OP_POLL, 12'd2228, 12'd2048, 1'b1, '{jdq_pkg::MOVE_NONE,  1'b1, 1'b0}},
		'{jdq_pkg::OP_POLL, 12'd2048, 12'd2048, 1'b1, '{jdq_pkg::MOVE_NONE,  1'b0, 1'b0}},
		'{jdq_pkg::OP_POLL, 12'd2048, 12'd0,    1'b1, '{jdq_pkg::MOVE_UP,    1'b1, 1'b0}},
		'{jdq_pkg::OP_POLL, 12'd2048, 12'd2048, 1'b1, '{jdq_pkg::MOVE_NONE,  1'b0, 1'b0}},
		// exactly at the move threshold, no event
		'{jdq_pkg::OP_POLL, 12'd1148, 12'd2048, 1'b1, '{jdq_pkg::MOVE_NONE,  1'b0, 1'b0}},
		'{jdq_pkg::OP_POLL, 12'd1147, 12'd2048, 1'b1, '{jdq_pkg::MOVE_LEFT,  1'b1, 1'b0}},
		'{jdq_pkg::OP_POLL, 12'd2048, 12'd2048, 1'b1, '{jdq_pkg::MOVE_NONE,  1'b0, 1'b0}},
		'{jdq_pkg::OP_POLL, 12'd2948, 12'd2948, 1'b1, '{jdq_pkg::MOVE_NONE,  1'b0, 1'b0}},
		// right wins over up
		'{jdq_pkg::OP_POLL, 12'd2949, 12'd0,    1'b1, '{jdq_pkg::MOVE_RIGHT, 1'b1, 1'b0}},
		'{jdq_pkg::OP_POLL, 12'd2048, 12'd2048, 1'b1, '{jdq_pkg::MOVE_NONE,  1'b0, 1'b0}},
		'{jdq_pkg::OP_POLL, 12'd2048, 12'd1147, 1'b1, '{jdq_pkg::MOVE_UP,    1'b1, 1'b0}},
		'{jdq_pkg::OP_POLL, 12'd2048, 12'd2048, 1'b1, '{jdq_pkg::MOVE_NONE,  1'b0, 1'b0}},
		// left wins over down
		'{jdq_pkg::OP_POLL, 12'd0,    12'd4095, 1'b1, '{jdq_pkg::MOVE_LEFT,  1'b1, 1'b0}},
		'{jdq_pkg::OP_POLL, 12'd2048, 12'd2048, 1'b1, '{jdq_pkg::MOVE_NONE,  1'b0, 1'b0}},
		'{jdq_pkg::OP_CAL,  12'd0,    12'd0,    1'b1, '{jdq_pkg::MOVE_NONE,  1'b0, 1'b0}},
		'{jdq_pkg::OP_CAL,  12'd4095, 12'd4095, 1'b1, '{jdq_pkg::MOVE_NONE,  1'b0, 1'b0}},
		'{jdq_pkg::OP_POLL, 12'd4095, 12'd2048, 1'b0, '{jdq_pkg::MOVE_NONE,  1'b0, 1'b0}},
		// calibration beat leaves the latch as it was
		'{jdq_pkg::OP_CAL,  12'd2048, 12'd2048, 1'b1, '{jdq_pkg::MOVE_NONE,  1'b1, 1'b0}}
	};

	joystick_direction_qualifier_top #(
		.CAL_SAMPLES(CAL_SAMPLES)
	) dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic jdq_pkg::sample_t clamp_threshold(int range);
		int v;
		v = (range * int'(cur_cfg.move_percent)) / 100;
		if (v < int'(cur_cfg.min_threshold))
			return cur_cfg.min_threshold;
		if (v > int'(cur_cfg.max_threshold))
			return cur_cfg.max_threshold;
		return jdq_pkg::sample_t'(v);
	endfunction

	function automatic jdq_pkg::sample_t near_sample(int base, int spread);
		int v;
		v = base - spread + int'($urandom_range(2 * spread));
		if (v < 0)
			v = 0;
		else if (v > SAMPLE_MAX)
			v = SAMPLE_MAX;
		return jdq_pkg::sample_t'(v);
	endfunction

	task automatic qualify_beat(input logic op, input jdq_pkg::sample_t xs,
			input jdq_pkg::sample_t ys, output jdq_pkg::result_t res);
		int            dx;
		int            dy;
		int            rd;
		jdq_pkg::dir_t dir;
		dir = jdq_pkg::MOVE_NONE;
		if (op == jdq_pkg::OP_CAL) begin
			sum_x = sum_x + jdq_pkg::SUM_W'(xs);
			sum_y = sum_y + jdq_pkg::SUM_W'(ys);
			if (cal_count + 1 >= CAL_SAMPLES) begin
				centre_x = jdq_pkg::sample_t'(int'(sum_x) / CAL_SAMPLES);
				centre_y = jdq_pkg::sample_t'(int'(sum_y) / CAL_SAMPLES);
				// full scale below centre gives a negative range, clamped up to min
				thr[SIDE_LEFT]  = clamp_threshold(int'(centre_x));
				thr[SIDE_RIGHT] = clamp_threshold(int'(cur_cfg.adc_full_scale) - int'(centre_x));
				thr[SIDE_UP]    = clamp_threshold(int'(centre_y));
				thr[SIDE_DOWN]  = clamp_threshold(int'(cur_cfg.adc_full_scale) - int'(centre_y));
				sum_x     = '0;
				sum_y     = '0;
				cal_count = 0;
				cal_done  = 1'b1;
				cal_sets++;
			end else begin
				cal_count++;
			end
		end else begin
			dx = int'(xs) - int'(centre_x);
			dy = int'(ys) - int'(centre_y);
			rd = int'(cur_cfg.release_distance);
			if (latch_q) begin
				if (dx < rd && dx > -rd && dy < rd && dy > -rd)
					latch_q = 1'b0;
			end else begin
				if (dx < -int'(thr[SIDE_LEFT]))
					dir = jdq_pkg::MOVE_LEFT;
				else if (dx > int'(thr[SIDE_RIGHT]))
					dir = jdq_pkg::MOVE_RIGHT;
				else if (dy > int'(thr[SIDE_DOWN]))
					dir = jdq_pkg::MOVE_DOWN;
				else if (dy < -int'(thr[SIDE_UP]))
					dir = jdq_pkg::MOVE_UP;
				if (dir != jdq_pkg::MOVE_NONE)
					latch_q = 1'b1;
			end
		end
		dir_events[dir]++;
		res.direction        = dir;
		res.awaiting_release = latch_q;
		res.calibrated       = cal_done;
	endtask

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	// offer one beat, wait for acceptance, then queue what it should produce
	task automatic push_beat(input logic op, input jdq_pkg::sample_t xs,
			input jdq_pkg::sample_t ys, input logic typed, input jdq_pkg::result_t want);
		jdq_pkg::result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		x_sample  <= xs;
		y_sample  <= ys;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		qualify_beat(op, xs, ys, predicted);
		expected_results.push_back(typed ? want : predicted);
		beats_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_settings(input jdq_pkg::cfg_t c);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= jdq_pkg::CFG_MOVE_PERCENT;
		cfg_data  <= jdq_pkg::CFG_DATA_W'(c.move_percent);
		@(posedge clk);
		cfg_index <= jdq_pkg::CFG_MIN_THRESHOLD;
		cfg_data  <= c.min_threshold;
		@(posedge clk);
		cfg_index <= jdq_pkg::CFG_MAX_THRESHOLD;
		cfg_data  <= c.max_threshold;
		@(posedge clk);
		cfg_index <= jdq_pkg::CFG_RELEASE_DISTANCE;
		cfg_data  <= c.release_distance;
		@(posedge clk);
		cfg_index <= jdq_pkg::CFG_ADC_FULL_SCALE;
		cfg_data  <= c.adc_full_scale;
		@(posedge clk);
		cfg_we  <= 1'b0;
		cur_cfg = c;
	endtask

	// calibration sets at rest, then deflect / return cycles and random beats, with some noise
	task automatic run_phase(input int n_beats);
		int target;
		int cal_left;
		int kind;
		int side;
		int off;
		int px;
		int py;
		int rd;
		int bx;
		int by;
		target   = beats_sent + n_beats;
		cal_left = CAL_SAMPLES - cal_count;
		bx       = int'($urandom_range(SAMPLE_MAX));
		by       = int'($urandom_range(SAMPLE_MAX));
		while (beats_sent < target) begin
			if (beats_sent == target - n_beats / 2)
				drain_results();
			if (cal_left > 0) begin
				push_beat(jdq_pkg::OP_CAL, near_sample(bx, 6), near_sample(by, 6), 1'b0, '0);
				cal_left--;
			end else begin
				kind = int'($urandom_range(99));
				if (kind < 8) begin
					push_beat(1'($urandom_range(1)),
						jdq_pkg::sample_t'($urandom_range(SAMPLE_MAX)),
						jdq_pkg::sample_t'($urandom_range(SAMPLE_MAX)), 1'b0, '0);
				end else if (kind < 12) begin
					cal_left = CAL_SAMPLES - cal_count;
					bx = ($urandom_range(7) == 0) ? SAMPLE_MAX * int'($urandom_range(1))
						: int'($urandom_range(SAMPLE_MAX));
					by = ($urandom_range(7) == 0) ? SAMPLE_MAX * int'($urandom_range(1))
						: int'($urandom_range(SAMPLE_MAX));
				end else if (kind < 55) begin
					side = int'($urandom_range(3));
					// half the moves land right at the threshold
					off = ($urandom_range(1) == 0) ? int'(thr[side]) - 2 + int'($urandom_range(4))
						: int'(thr[side]) + int'($urandom_range(2500));
					px = int'(centre_x);
					py = int'(centre_y);
					case (side)
						SIDE_LEFT: begin
							px -= off;
						end
						SIDE_RIGHT: begin
							px += off;
						end
						SIDE_UP: begin
							py -= off;
						end
						default: begin
							py += off;
						end
					endcase
					push_beat(jdq_pkg::OP_POLL, near_sample(px, (side < 2) ? 0 : 40),
						near_sample(py, (side < 2) ? 40 : 0), 1'b0, '0);
				end else begin
					rd = int'(cur_cfg.release_distance);
					push_beat(jdq_pkg::OP_POLL, near_sample(int'(centre_x), rd + 2),
						near_sample(int'(centre_y), rd + 2), 1'b0, '0);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing expected, direction %0d",
					direction));
			end else begin
				oldest = expected_results.pop_front();
				if (direction !== oldest.direction)
					report_mismatch($sformatf("direction got %0d expected %0d",
						direction, oldest.direction));
				if (awaiting_release !== oldest.awaiting_release)
					report_mismatch($sformatf("awaiting_release got %0b expected %0b",
						awaiting_release, oldest.awaiting_release));
				if (calibrated !== oldest.calibrated)
					report_mismatch($sformatf("calibrated got %0b expected %0b",
						calibrated, oldest.calibrated));
			end
		end
	end

	// watchdog set far above the slowest legal run
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		jdq_pkg::cfg_t phase_cfg [N_PHASES];
		cur_cfg   = '{jdq_pkg::MOVE_PERCENT_RST, jdq_pkg::MIN_THRESH_RST,
			jdq_pkg::MAX_THRESH_RST, jdq_pkg::RELEASE_RST, jdq_pkg::FULL_SCALE_RST};
		latch_q   = 1'b0;
		centre_x  = jdq_pkg::CENTRE_RST;
		centre_y  = jdq_pkg::CENTRE_RST;
		foreach (thr[i])
			thr[i] = jdq_pkg::THRESH_RST;
		sum_x     = '0;
		sum_y     = '0;
		cal_count = 0;
		cal_done  = 1'b0;
		foreach (dir_events[i])
			dir_events[i] = 0;

		phase_cfg[0] = '{jdq_pkg::MOVE_PERCENT_RST, jdq_pkg::MIN_THRESH_RST,
			jdq_pkg::MAX_THRESH_RST, jdq_pkg::RELEASE_RST, jdq_pkg::FULL_SCALE_RST};
		phase_cfg[1] = '{7'd0,   12'd0,    12'd4095, 12'd4095, 12'd4095};
		// release distance zero keeps the latch set for good
		phase_cfg[2] = '{7'd100, 12'd0,    12'd4095, 12'd0,    12'd4095};
		// minimum above maximum, smallest full scale
		phase_cfg[3] = '{7'd100, 12'd4095, 12'd0,    12'd4095, 12'd1};
		phase_cfg[4] = '{7'd30,  12'd100,  12'd2000, 12'd300,  12'd2500};
		phase_cfg[6] = '{7'd75,  12'd0,    12'd0,    12'd50,   12'd4095};
		phase_cfg[8] = '{7'd100, 12'd0,    12'd4095, 12'd1,    12'd4095};
		foreach (phase_cfg[i]) begin
			if (i == 5 || i == 7 || i == 9)
				phase_cfg[i] = '{7'($urandom_range(100)), 12'($urandom_range(600)),
					12'($urandom_range(4095, 200)), 12'($urandom_range(600)),
					12'($urandom_range(4095, 1))};
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			push_beat(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
				directed_rows[i].typed, directed_rows[i].want);

		for (int p = 0; p < N_PHASES; p++) begin
			if (p == 4) begin
				send_idle_pct = 57;
				recv_idle_pct = 14;
			end
			if (p == 7) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			load_settings(phase_cfg[p]);
			run_phase(PHASE_BEATS);
		end
		drain_results();

		$display("run covered %0d input beats under %0d register settings, %0d calibration sets",
			beats_sent, N_PHASES, cal_sets);
		$display("checked %0d results: left %0d right %0d down %0d up %0d events",
			results_seen, dir_events[jdq_pkg::MOVE_LEFT], dir_events[jdq_pkg::MOVE_RIGHT],
			dir_events[jdq_pkg::MOVE_DOWN], dir_events[jdq_pkg::MOVE_UP]);
		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
